// ===== hdl/pngu_pkg.sv =====
// ---------------------------------------------------------------------------
// pngu_pkg
// Shared constants, register indexes and control types of the PNG scanline
// unfilter.
// ---------------------------------------------------------------------------
package pngu_pkg;

   localparam int MAX_ROW_BYTES_DEF = 16384;
   localparam int MAX_BPP_DEF       = 4;
   localparam int QUEUE_DEPTH       = 4;

   localparam int WIDTH_W     = 13;
   localparam int HEIGHT_W    = 16;
   localparam int BPP_W       = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd2;

   typedef enum logic [2:0] {
      FILT_NONE,
      FILT_SUB,
      FILT_UP,
      FILT_AVG,
      FILT_PAETH,
      FILT_BAD
   } filter_type;

   typedef struct packed {
      filter_type filt;
      logic       has_up;
      logic       has_left;
      logic       row_end;
      logic       image_end;
   } ctl_type;

endpackage

// ===== hdl/png_scanline_unfilter.sv =====
// ---------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth) over an
// inflated byte stream, with a prior-row line store.
//
//   Channel  Handshake              Dir  Transaction
//   req      req_valid/req_stall    in   one stream byte (filter type at row start)
//   rsp      rsp_valid/rsp_stall    out  one pixel byte with row/image end, bad filter
//   csr      csr_we                 in   one register write, no read-back
//
// One byte per cycle sustained while rsp_stall is low; a filter type byte
// yields no result. A result passes queue write, line store read, and
// reconstruct into the output register. The rate is set by the left-byte
// loop in the reconstruct stage and the line store's single read and write
// port.
// Synchronous reset clears positions, queue and history; the line store is
// not cleared. rsp_stall holds the output register, then the stage and the
// queue fill, then req_stall rises.
// ---------------------------------------------------------------------------
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES       = pngu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_BYTES_PER_PIXEL = pngu_pkg::MAX_BPP_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_filtered_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_pixel_byte,
   output logic                            rsp_row_end,
   output logic                            rsp_image_end,
   output logic                            rsp_bad_filter,
   input  logic                            csr_we,
   input  logic [pngu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pngu_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW   = $clog2(MAX_ROW_BYTES);
   localparam int SW   = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
   localparam int CTLW = $bits(pngu_pkg::ctl_type);
   localparam int QW   = CTLW + SW + AW + 8;

   logic [pngu_pkg::WIDTH_W-1:0]  width_ff;
   logic [pngu_pkg::HEIGHT_W-1:0] height_ff;
   logic [pngu_pkg::BPP_W-1:0]    bpp_ff;

   logic              f_push;
   pngu_pkg::ctl_type f_ctl;
   logic [SW-1:0]     f_slot;
   logic [AW-1:0]     f_j;
   logic [7:0]        f_byte;

   logic              q_full;
   logic              q_not_empty;
   logic              q_pop;
   logic [QW-1:0]     q_wdata;
   logic [QW-1:0]     q_rdata;

   pngu_pkg::ctl_type b_ctl;
   logic [SW-1:0]     b_slot;
   logic [AW-1:0]     b_j;
   logic [7:0]        b_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pngu_pkg::WIDTH_W'(1);
         height_ff <= pngu_pkg::HEIGHT_W'(1);
         bpp_ff    <= pngu_pkg::BPP_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            pngu_pkg::CSR_IMAGE_WIDTH:     width_ff  <= csr_wdata[pngu_pkg::WIDTH_W-1:0];
            pngu_pkg::CSR_IMAGE_HEIGHT:    height_ff <= csr_wdata[pngu_pkg::HEIGHT_W-1:0];
            pngu_pkg::CSR_BYTES_PER_PIXEL: bpp_ff    <= csr_wdata[pngu_pkg::BPP_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = q_full;

   pngu_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_BPP       (MAX_BYTES_PER_PIXEL)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_filtered_byte (req_filtered_byte),
      .q_full            (q_full),
      .image_width       (width_ff),
      .image_height      (height_ff),
      .bytes_per_pixel   (bpp_ff),
      .push              (f_push),
      .push_ctl          (f_ctl),
      .push_slot         (f_slot),
      .push_j            (f_j),
      .push_byte         (f_byte)
   );

   assign q_wdata = {f_ctl, f_slot, f_j, f_byte};

   pngu_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (q_rdata)
   );

   assign b_ctl  = pngu_pkg::ctl_type'(q_rdata[QW-1 -: CTLW]);
   assign b_slot = q_rdata[AW+8 +: SW];
   assign b_j    = q_rdata[8 +: AW];
   assign b_byte = q_rdata[7:0];

   pngu_recon #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .MAX_BPP       (MAX_BYTES_PER_PIXEL)
   ) u_recon (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_ctl          (b_ctl),
      .q_slot         (b_slot),
      .q_j            (b_j),
      .q_byte         (b_byte),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end),
      .rsp_bad_filter (rsp_bad_filter)
   );

endmodule

// ===== hdl/pngu_queue.sv =====
// ---------------------------------------------------------------------------
// pngu_queue
// Small register queue that decouples the row tracker from reconstruction.
// ---------------------------------------------------------------------------
module pngu_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (pngu_pkg::QUEUE_DEPTH > 1) ? $clog2(pngu_pkg::QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(pngu_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [pngu_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNTW'(pngu_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(pngu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(pngu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/pngu_front.sv =====
// ---------------------------------------------------------------------------
// pngu_front
// Accepts stream bytes, tracks column and row, classifies the row filter and
// issues one reconstruction job per data byte.
// ---------------------------------------------------------------------------
module pngu_front #(
   parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_BPP       = pngu_pkg::MAX_BPP_DEF,
   localparam int AW = $clog2(MAX_ROW_BYTES),
   localparam int SW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [7:0]                    req_filtered_byte,
   input  logic                          q_full,
   input  logic [pngu_pkg::WIDTH_W-1:0]  image_width,
   input  logic [pngu_pkg::HEIGHT_W-1:0] image_height,
   input  logic [pngu_pkg::BPP_W-1:0]    bytes_per_pixel,
   output logic                          push,
   output pngu_pkg::ctl_type             push_ctl,
   output logic [SW-1:0]                 push_slot,
   output logic [AW-1:0]                 push_j,
   output logic [7:0]                    push_byte
);

   localparam int CW = $clog2(MAX_ROW_BYTES + 1);
   localparam int BW = $clog2(MAX_BPP + 1);
   localparam int PRW = pngu_pkg::WIDTH_W + BW;
   localparam int HW = pngu_pkg::HEIGHT_W;

   logic [CW-1:0]          col_ff, col_in;
   logic [HW-1:0]          row_ff, row_in;
   pngu_pkg::filter_type   filt_ff, filt_in;
   logic [SW-1:0]          cnt_ff [MAX_BPP];
   logic [SW-1:0]          cnt_in [MAX_BPP];

   logic                          accept;
   logic [BW-1:0]                 bpp_eff;
   logic [pngu_pkg::WIDTH_W-1:0]  width_eff;
   logic [HW-1:0]                 height_eff;
   logic [PRW-1:0]                row_bytes;
   logic [CW-1:0]                 stride;
   logic [CW-1:0]                 col_m1;
   logic [AW-1:0]                 j;
   logic [SW-1:0]                 slot_idx;
   logic                          row_end;
   logic                          last_row;
   logic                          has_left;

   function automatic pngu_pkg::filter_type classify(input logic [7:0] code);
      pngu_pkg::filter_type f;
      case (code)
         8'd0:    f = pngu_pkg::FILT_NONE;
         8'd1:    f = pngu_pkg::FILT_SUB;
         8'd2:    f = pngu_pkg::FILT_UP;
         8'd3:    f = pngu_pkg::FILT_AVG;
         8'd4:    f = pngu_pkg::FILT_PAETH;
         default: f = pngu_pkg::FILT_BAD;
      endcase
      return f;
   endfunction

   always_comb begin
      if (bytes_per_pixel == '0) begin
         bpp_eff = BW'(1);
      end else if (32'(bytes_per_pixel) > 32'(MAX_BPP)) begin
         bpp_eff = BW'(MAX_BPP);
      end else begin
         bpp_eff = BW'(bytes_per_pixel);
      end
      width_eff  = (image_width == '0) ? pngu_pkg::WIDTH_W'(1) : image_width;
      height_eff = (image_height == '0) ? HW'(1) : image_height;
      row_bytes  = PRW'(width_eff) * PRW'(bpp_eff);
      stride     = (32'(row_bytes) > 32'(MAX_ROW_BYTES)) ? CW'(MAX_ROW_BYTES) : CW'(row_bytes);
      col_m1     = col_ff - CW'(1);
      j          = col_m1[AW-1:0];
      slot_idx   = SW'(bpp_eff - BW'(1));
      row_end    = (col_ff >= stride);
      last_row   = ((HW + 1)'(row_ff) + (HW + 1)'(1)) >= (HW + 1)'(height_eff);
      has_left   = 32'(j) >= 32'(bpp_eff);
   end

   assign accept    = req_valid && !q_full;
   assign push_slot = cnt_ff[slot_idx];
   assign push_j    = j;
   assign push_byte = req_filtered_byte;

   always_comb begin
      push_ctl.filt      = filt_ff;
      push_ctl.has_up    = (row_ff != '0);
      push_ctl.has_left  = has_left;
      push_ctl.row_end   = row_end;
      push_ctl.image_end = row_end && last_row;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      filt_in = filt_ff;
      cnt_in  = cnt_ff;
      push    = 1'b0;
      if (accept) begin
         if (col_ff == '0) begin
            filt_in = classify(req_filtered_byte);
            col_in  = CW'(1);
            for (int i = 0; i < MAX_BPP; i++) begin
               cnt_in[i] = '0;
            end
         end else begin
            push = 1'b1;
            if (row_end) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + HW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
            for (int i = 0; i < MAX_BPP; i++) begin
               cnt_in[i] = (cnt_ff[i] == SW'(i)) ? '0 : cnt_ff[i] + SW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         filt_ff <= pngu_pkg::FILT_NONE;
         for (int i = 0; i < MAX_BPP; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         filt_ff <= filt_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== hdl/pngu_recon.sv =====
// ---------------------------------------------------------------------------
// pngu_recon
// Reads the prior row, rebuilds each byte with its row filter, writes the
// line store and left/up history, and holds the result for the sink.
// ---------------------------------------------------------------------------
module pngu_recon #(
   parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_BPP       = pngu_pkg::MAX_BPP_DEF,
   localparam int AW = $clog2(MAX_ROW_BYTES),
   localparam int SW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pngu_pkg::ctl_type q_ctl,
   input  logic [SW-1:0]     q_slot,
   input  logic [AW-1:0]     q_j,
   input  logic [7:0]        q_byte,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_pixel_byte,
   output logic              rsp_row_end,
   output logic              rsp_image_end,
   output logic              rsp_bad_filter
);

   logic [7:0]        line_mem [MAX_ROW_BYTES];
   logic [7:0]        left_hist_ff [MAX_BPP];
   logic [7:0]        up_hist_ff [MAX_BPP];

   logic              s1_valid_ff, s1_valid_in;
   pngu_pkg::ctl_type s1_ctl_ff;
   logic [SW-1:0]     s1_slot_ff;
   logic [AW-1:0]     s1_j_ff;
   logic [7:0]        s1_byte_ff;
   logic [7:0]        up_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_row_end_ff;
   logic              rsp_image_end_ff;
   logic              rsp_bad_ff;

   logic              out_free;
   logic              s1_adv;
   logic [7:0]        left_v;
   logic [7:0]        up_v;
   logic [7:0]        upleft_v;
   logic [8:0]        avg_sum;
   logic [7:0]        pred;
   logic [7:0]        val;

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] d_bc;
      logic signed [9:0] d_ac;
      logic signed [9:0] d_abc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      logic [7:0]        r;
      d_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
      d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
      d_abc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      pa    = (d_bc < 0) ? 10'(-d_bc) : 10'(d_bc);
      pb    = (d_ac < 0) ? 10'(-d_ac) : 10'(d_ac);
      pc    = (d_abc < 0) ? 10'(-d_abc) : 10'(d_abc);
      if (pa <= pb && pa <= pc) begin
         r = a;
      end else if (pb <= pc) begin
         r = b;
      end else begin
         r = c;
      end
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign q_pop    = q_valid && (!s1_valid_ff || out_free);

   always_comb begin
      left_v   = s1_ctl_ff.has_left ? left_hist_ff[s1_slot_ff] : 8'd0;
      up_v     = s1_ctl_ff.has_up ? up_rd_ff : 8'd0;
      upleft_v = (s1_ctl_ff.has_up && s1_ctl_ff.has_left) ? up_hist_ff[s1_slot_ff] : 8'd0;
      avg_sum  = {1'b0, left_v} + {1'b0, up_v};
      case (s1_ctl_ff.filt)
         pngu_pkg::FILT_NONE:  pred = 8'd0;
         pngu_pkg::FILT_SUB:   pred = left_v;
         pngu_pkg::FILT_UP:    pred = up_v;
         pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
         pngu_pkg::FILT_PAETH: pred = paeth(left_v, up_v, upleft_v);
         default:              pred = 8'd0;
      endcase
      val = s1_byte_ff + pred;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_BPP; i++) begin
            left_hist_ff[i] <= 8'd0;
            up_hist_ff[i]   <= 8'd0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            left_hist_ff[s1_slot_ff] <= val;
            up_hist_ff[s1_slot_ff]   <= up_v;
         end
      end
   end

   // forward the byte being written when the next job reads the same column
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ctl_ff  <= q_ctl;
         s1_slot_ff <= q_slot;
         s1_j_ff    <= q_j;
         s1_byte_ff <= q_byte;
         up_rd_ff   <= (s1_adv && (s1_j_ff == q_j)) ? val : line_mem[q_j];
      end
      if (s1_adv) begin
         line_mem[s1_j_ff] <= val;
         rsp_byte_ff       <= val;
         rsp_row_end_ff    <= s1_ctl_ff.row_end;
         rsp_image_end_ff  <= s1_ctl_ff.image_end;
         rsp_bad_ff        <= (s1_ctl_ff.filt == pngu_pkg::FILT_BAD);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_byte_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_image_end  = rsp_image_end_ff;
   assign rsp_bad_filter = rsp_bad_ff;

endmodule
